FILE: hdl/gas_pkg.sv
// Shared types and constants for the direct-sum gravity acceleration block.
// Used by every module of the block; depends on nothing.
package gas_pkg;

    // Body table.
    localparam int MAX_BODIES = 16;
    localparam int IDX_W      = $clog2(MAX_BODIES);

    // Field widths.
    localparam int SLOT_W = 4;
    localparam int POS_W  = 48;
    localparam int MU_W   = 64;

    // Stream packing.
    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 152;

    // Datapath widths.
    localparam int D_W     = POS_W + 1;       // difference magnitude
    localparam int ROOT_W  = 67;              // floor(sqrt(S * 2^32))
    localparam int SQN_W   = 2 * ROOT_W;      // radicand
    localparam int REM_W   = ROOT_W + 3;      // root remainder
    localparam int PROD_W  = 200;             // multiplier accumulator
    localparam int CNT_W   = 7;
    localparam int NUM_W   = MU_W + D_W + 98; // mu * |d| * 2^98
    localparam int Q_W     = 56;              // quotient bits kept
    localparam int DSH_W   = PROD_W + Q_W;    // shifted divisor
    localparam int TERM_W  = 55;
    localparam int SUM_W   = TERM_W + 2 + IDX_W;

    // Action codes.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                  is_query;
        logic [IDX_W-1:0]      slot;
        logic [2:0][POS_W-1:0] pos;   // z, y, x from the top down
        logic [MU_W-1:0]       mu;
    } t_item;

endpackage

FILE: hdl/gas_front.sv
// Front end: accepts requests from the input stream, drops loads aimed past
// the body table and passes the rest on as classified items. Uses gas_pkg.
module gas_front import gas_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 o_push,
    output t_item                o_item,
    input  logic                 i_full
);

    logic  r_valid;
    t_item r_item;
    logic  r_keep;
    logic  w_take;
    logic  w_slot_ok;

    // The stage is free when empty or when its item moves on or is dropped this cycle.
    assign o_push        = r_valid && r_keep && !i_full;
    assign s_axis_tready = !r_valid || o_push || !r_keep;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign o_item        = r_item;

    // Loads to a slot beyond the table are accepted and discarded.
    assign w_slot_ok = (32'(s_axis_tdata[SLOT_W-1:0]) < MAX_BODIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push || !r_keep) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.is_query <= (s_axis_tuser == ACT_QUERY);
            r_item.slot     <= IDX_W'(s_axis_tdata[SLOT_W-1:0]);
            r_item.pos[0]   <= s_axis_tdata[SLOT_W +: POS_W];
            r_item.pos[1]   <= s_axis_tdata[SLOT_W+POS_W +: POS_W];
            r_item.pos[2]   <= s_axis_tdata[SLOT_W+2*POS_W +: POS_W];
            r_item.mu       <= s_axis_tdata[SLOT_W+3*POS_W +: MU_W];
            r_keep          <= (s_axis_tuser == ACT_QUERY) || w_slot_ok;
        end
    end

endmodule

FILE: hdl/gas_fifo.sv
// Two-entry queue that decouples the front end from the compute engine.
// Uses gas_pkg for the item type.
module gas_fifo import gas_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

FILE: hdl/gas_back.sv
// Compute engine: keeps the body table and walks it for each query with a
// shared shift-add multiplier, a bit-pair square root and a restoring divider.
// Uses gas_pkg.
module gas_back import gas_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_BODY = 13'b0000000000010,
        S_SQ   = 13'b0000000000100,
        S_SQZ  = 13'b0000000001000,
        S_ROOT = 13'b0000000010000,
        S_R2   = 13'b0000000100000,
        S_R3   = 13'b0000001000000,
        S_AX   = 13'b0000010000000,
        S_NUM  = 13'b0000100000000,
        S_DIV  = 13'b0001000000000,
        S_ADV  = 13'b0010000000000,
        S_NEXT = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    localparam logic signed [SUM_W-1:0] LIM_HI = {{(SUM_W-47){1'b0}}, {47{1'b1}}};
    localparam logic signed [SUM_W-1:0] LIM_LO = {{(SUM_W-47){1'b1}}, {47{1'b0}}};
    localparam logic [TERM_W-1:0]       TERM_CLAMP = {1'b1, {(TERM_W-1){1'b0}}};

    t_state r_state, n_state;

    // Body table.
    logic [POS_W-1:0] r_tpos [3][MAX_BODIES];
    logic [MU_W-1:0]  r_tmu  [MAX_BODIES];
    logic [MAX_BODIES-1:0] r_tvalid;

    // Query and per-body working registers.
    logic [POS_W-1:0]        r_qpos [3];
    logic [D_W-1:0]          r_dmag [3], n_dmag [3];
    logic [2:0]              r_dneg, n_dneg;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [1:0]              r_ax, n_ax;
    logic signed [SUM_W-1:0] r_sum [3], n_sum [3];
    logic                    r_flag, n_flag;

    // Shared multiplier.
    logic [PROD_W-1:0] r_mcand, n_mcand;
    logic [ROOT_W-1:0] r_mplier, n_mplier;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] w_acc_step;

    // Square root.
    logic [SQN_W-1:0]  r_sqn, n_sqn;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [REM_W+1:0]  w_rtry;
    logic [REM_W+1:0]  w_rtrial;

    // Divider.
    logic [PROD_W-1:0] r_den, n_den;
    logic [NUM_W-1:0]  r_drem, n_drem;
    logic [DSH_W-1:0]  r_dsh, n_dsh;
    logic [Q_W-1:0]    r_q, n_q;
    logic              w_ge;
    logic              w_clamp;
    logic [TERM_W-1:0] w_tmag;
    logic signed [SUM_W-1:0] w_term;

    // Output register.
    logic                  r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    logic [MU_W-1:0] w_mu;
    logic            w_load;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign o_pop         = (r_state == S_IDLE) && i_valid;
    assign w_load        = o_pop && !i_item.is_query;
    assign w_mu          = r_tmu[r_idx];

    // One step of the multiplier, the root and the divider.
    assign w_acc_step = r_acc + (r_mplier[0] ? r_mcand : '0);
    assign w_rtry     = {r_rem, r_sqn[SQN_W-1 -: 2]};
    assign w_rtrial   = {{(REM_W+2-ROOT_W-2){1'b0}}, r_root, 2'b01};
    assign w_ge       = ({{(DSH_W-NUM_W){1'b0}}, r_drem} >= r_dsh);
    assign n_q        = {r_q[Q_W-2:0], w_ge};
    // A quotient of 2^54 or more is clamped.
    assign w_clamp    = n_q[Q_W-1] || n_q[Q_W-2];
    assign w_tmag     = w_clamp ? TERM_CLAMP : n_q[TERM_W-1:0];
    assign w_term     = $signed({{(SUM_W-TERM_W){1'b0}}, w_tmag});

    always_comb begin
        logic signed [D_W-1:0] d;
        logic signed [SUM_W-1:0] s;
        d        = '0;
        s        = '0;
        n_state  = r_state;
        n_idx    = r_idx;
        n_ax     = r_ax;
        n_dneg   = r_dneg;
        n_flag   = r_flag;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_sqn    = r_sqn;
        n_rem    = r_rem;
        n_root   = r_root;
        n_den    = r_den;
        n_drem   = r_drem;
        n_dsh    = r_dsh;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        for (int a = 0; a < 3; a++) begin
            n_dmag[a] = r_dmag[a];
            n_sum[a]  = r_sum[a];
        end

        case (r_state)
            // Take the next request: loads finish here, queries start a walk.
            S_IDLE: begin
                if (o_pop && i_item.is_query) begin
                    n_idx  = '0;
                    n_flag = 1'b0;
                    for (int a = 0; a < 3; a++) begin
                        n_sum[a] = '0;
                    end
                    n_state = S_BODY;
                end
            end
            // Form the differences and start the sum of squares; skip an empty slot.
            S_BODY: begin
                if (r_tvalid[r_idx]) begin
                    for (int a = 0; a < 3; a++) begin
                        d = $signed({r_qpos[a][POS_W-1], r_qpos[a]})
                          - $signed({r_tpos[a][r_idx][POS_W-1], r_tpos[a][r_idx]});
                        n_dneg[a] = d[D_W-1];
                        n_dmag[a] = d[D_W-1] ? D_W'(-d) : D_W'(d);
                    end
                    n_mcand  = PROD_W'(n_dmag[0]);
                    n_mplier = ROOT_W'(n_dmag[0]);
                    n_acc    = '0;
                    n_cnt    = CNT_W'(D_W - 1);
                    n_ax     = 2'd0;
                    n_state  = S_SQ;
                end else begin
                    n_state = S_NEXT;
                end
            end
            // Squares of the three axes accumulate into one sum.
            S_SQ: begin
                n_acc    = w_acc_step;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (r_ax == 2'd2) begin
                        n_state = S_SQZ;
                    end else begin
                        n_ax     = r_ax + 1'b1;
                        n_mcand  = PROD_W'(r_dmag[n_ax]);
                        n_mplier = ROOT_W'(r_dmag[n_ax]);
                        n_cnt    = CNT_W'(D_W - 1);
                    end
                end
            end
            // A coincident body adds nothing; otherwise start the root.
            S_SQZ: begin
                if (r_acc == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_sqn   = {r_acc[SQN_W-33:0], 32'b0};
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(ROOT_W - 1);
                    n_state = S_ROOT;
                end
            end
            // One root bit per cycle from two radicand bits.
            S_ROOT: begin
                n_sqn = r_sqn << 2;
                if (w_rtry >= w_rtrial) begin
                    n_rem  = REM_W'(w_rtry - w_rtrial);
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = REM_W'(w_rtry);
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_mcand  = PROD_W'(n_root);
                    n_mplier = n_root;
                    n_acc    = '0;
                    n_cnt    = CNT_W'(ROOT_W - 1);
                    n_state  = S_R2;
                end
            end
            // R squared, then R cubed.
            S_R2: begin
                n_acc    = w_acc_step;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_mcand  = w_acc_step;
                    n_mplier = r_root;
                    n_acc    = '0;
                    n_cnt    = CNT_W'(ROOT_W - 1);
                    n_state  = S_R3;
                end
            end
            S_R3: begin
                n_acc    = w_acc_step;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_den   = w_acc_step;
                    n_ax    = 2'd0;
                    n_state = S_AX;
                end
            end
            // Start mu * |d| for this axis; a zero difference gives no term.
            S_AX: begin
                if (r_dmag[r_ax] == '0) begin
                    n_state = S_ADV;
                end else begin
                    n_mcand  = PROD_W'(w_mu);
                    n_mplier = ROOT_W'(r_dmag[r_ax]);
                    n_acc    = '0;
                    n_cnt    = CNT_W'(D_W - 1);
                    n_state  = S_NUM;
                end
            end
            S_NUM: begin
                n_acc    = w_acc_step;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_drem  = {w_acc_step[MU_W+D_W-1:0], 98'b0};
                    n_dsh   = {r_den, {Q_W{1'b0}}} >> 1;
                    n_cnt   = CNT_W'(Q_W - 1);
                    n_state = S_DIV;
                end
            end
            // One quotient bit per cycle; the last one also adds the term.
            S_DIV: begin
                if (w_ge) begin
                    n_drem = r_drem - r_dsh[NUM_W-1:0];
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    s = r_dneg[r_ax] ? w_term : -w_term;
                    n_sum[r_ax] = r_sum[r_ax] + s;
                    n_flag      = r_flag || w_clamp;
                    n_state     = S_ADV;
                end
            end
            S_ADV: begin
                if (r_ax == 2'd2) begin
                    n_state = S_NEXT;
                end else begin
                    n_ax    = r_ax + 1'b1;
                    n_state = S_AX;
                end
            end
            S_NEXT: begin
                if (32'(r_idx) == MAX_BODIES - 1) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_BODY;
                end
            end
            // Clip the sums into the output register once it is free.
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata = '0;
                    n_odata[3*POS_W] = r_flag;
                    for (int a = 0; a < 3; a++) begin
                        if (r_sum[a] > LIM_HI) begin
                            n_odata[a*POS_W +: POS_W] = LIM_HI[POS_W-1:0];
                            n_odata[3*POS_W]          = 1'b1;
                        end else if (r_sum[a] < LIM_LO) begin
                            n_odata[a*POS_W +: POS_W] = LIM_LO[POS_W-1:0];
                            n_odata[3*POS_W]          = 1'b1;
                        end else begin
                            n_odata[a*POS_W +: POS_W] = r_sum[a][POS_W-1:0];
                        end
                    end
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_tvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (w_load) begin
                r_tvalid[i_item.slot] <= 1'b1;
            end
        end
    end

    // Body table writes.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int a = 0; a < 3; a++) begin
                r_tpos[a][i_item.slot] <= i_item.pos[a];
            end
            r_tmu[i_item.slot] <= i_item.mu;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int a = 0; a < 3; a++) begin
                r_qpos[a] <= i_item.pos[a];
            end
        end
        for (int a = 0; a < 3; a++) begin
            r_dmag[a] <= n_dmag[a];
            r_sum[a]  <= n_sum[a];
        end
        r_dneg   <= n_dneg;
        r_idx    <= n_idx;
        r_ax     <= n_ax;
        r_flag   <= n_flag;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_sqn    <= n_sqn;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_den    <= n_den;
        r_drem   <= n_drem;
        r_dsh    <= n_dsh;
        r_q      <= (r_state == S_DIV) ? n_q : '0;
        r_odata  <= n_odata;
    end

endmodule

FILE: hdl/gravity_acceleration_sum.sv
// Top level of the direct-sum gravity acceleration block.
// Instantiates gas_front, gas_fifo and gas_back; uses gas_pkg.
//
//   channel   dir   tdata fields (low bit up)                   tuser
//   s_axis    in    slot, pos_x, pos_y, pos_z, grav_param       action
//   m_axis    out   accel_x, accel_y, accel_z, saturated        -
//
// A load is written to the table as the engine takes it. A query walks
// every table slot, skipping empty ones; for a body it forms the sum of
// squares, the root, R cubed and a quotient per nonzero axis, using the
// shared shift-add multiplier and the one-bit-per-cycle root and divider.
// Reset is synchronous and clears the table's valid marks.
// The two-entry queue and the output register let either side stall alone.
module gravity_acceleration_sum import gas_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // slot, pos_x, pos_y, pos_z, grav_param
    input  logic                  s_axis_tuser,  // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // accel_x, accel_y, accel_z, saturated
);

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_qvalid;
    t_item w_fitem;
    t_item w_qitem;

    gas_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (w_push),
        .o_item        (w_fitem),
        .i_full        (w_full)
    );

    gas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_item  (w_qitem)
    );

    gas_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_qvalid),
        .i_item        (w_qitem),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: hdl/gas_checker.sv
// Port-level checks for gravity_acceleration_sum, bound to the top level.
// Uses gas_pkg.
module gas_checker import gas_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [3:0] r_pend;

    // Queries accepted and not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend
                    + 4'(s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_QUERY))
                    - 4'(m_axis_tvalid && m_axis_tready);
        end
    end

    a_no_result_unasked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pend != 4'd0))
        else $error("result without a pending query");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("ports not idle after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind gravity_acceleration_sum gas_checker u_gas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/tb_top.sv
// Self-checking testbench for gravity_acceleration_sum: loads bodies, queries
// accelerations and compares each result with a bit-exact predictor.
// Depends on gas_pkg and the gravity_acceleration_sum RTL only.
module tb_top;
    import gas_pkg::*;

    typedef struct {
        logic               is_query;
        logic [3:0]         slot;
        logic signed [47:0] x, y, z;
        logic [63:0]        mu;
    } req_t;

    typedef struct {
        logic signed [47:0] ax, ay, az;
        logic               sat;
    } accel_t;

    typedef struct {
        req_t   req;
        bit     typed;    // expected result given below instead of predicted
        accel_t res;
    } row_t;

    localparam int N_RANDOM   = 1230;
    localparam int N_DIRECTED = 14;
    localparam longint TERM_CAP = 64'sd1 << 54;
    localparam longint OUT_HI   = (64'sd1 << 47) - 1;
    localparam longint OUT_LO   = -(64'sd1 << 47);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // slot, pos_x, pos_y, pos_z, grav_param
    logic                  s_axis_tuser = 1'b0; // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;       // accel_x, accel_y, accel_z, saturated

    // Testbench copy of the body table.
    logic signed [47:0] body_x [MAX_BODIES];
    logic signed [47:0] body_y [MAX_BODIES];
    logic signed [47:0] body_z [MAX_BODIES];
    logic [63:0]        body_mu [MAX_BODIES];
    bit                 body_valid [MAX_BODIES];

    accel_t accel_expected [$];
    int     n_errors = 0;
    int     n_loads = 0;
    int     n_queries = 0;
    int     n_results = 0;
    int     n_clamped = 0;
    bit     stim_done = 1'b0;

    gravity_acceleration_sum u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Direct sum of -mu*d/r^3 over the valid bodies, rounded as the block does.
    function automatic accel_t accel_at(logic signed [47:0] qx, qy, qz);
        longint      sum [3];
        longint      d [3];
        longint      mag;
        logic [255:0] s, rad, root, cand, r3, num, quot, dm;
        accel_t      res;
        bit          flag;
        flag = 1'b0;
        sum[0] = 0; sum[1] = 0; sum[2] = 0;
        for (int i = 0; i < MAX_BODIES; i++) begin
            if (!body_valid[i]) continue;
            d[0] = longint'(qx) - longint'(body_x[i]);
            d[1] = longint'(qy) - longint'(body_y[i]);
            d[2] = longint'(qz) - longint'(body_z[i]);
            s = '0;
            for (int a = 0; a < 3; a++) begin
                dm = '0;
                dm[63:0] = (d[a] < 0) ? -d[a] : d[a];
                s = s + dm * dm;
            end
            if (s == 0) continue;
            // Integer square root of S * 2^32, one bit at a time.
            rad = s << 32;
            root = '0;
            for (int b = 66; b >= 0; b--) begin
                cand = root | (256'd1 << b);
                if (cand * cand <= rad) root = cand;
            end
            r3 = root * root * root;
            for (int a = 0; a < 3; a++) begin
                if (d[a] == 0) continue;
                dm = '0;
                dm[63:0] = (d[a] < 0) ? -d[a] : d[a];
                num = '0;
                num[63:0] = body_mu[i];
                num = (num * dm) << 98;
                quot = num / r3;
                if (quot >= 256'(TERM_CAP)) begin
                    mag = TERM_CAP;
                    flag = 1'b1;
                end else begin
                    mag = quot[63:0];
                end
                sum[a] += (d[a] > 0) ? -mag : mag;
            end
        end
        for (int a = 0; a < 3; a++) begin
            if (sum[a] > OUT_HI) begin
                sum[a] = OUT_HI;
                flag = 1'b1;
            end else if (sum[a] < OUT_LO) begin
                sum[a] = OUT_LO;
                flag = 1'b1;
            end
        end
        res.ax = sum[0][47:0];
        res.ay = sum[1][47:0];
        res.az = sum[2][47:0];
        res.sat = flag;
        return res;
    endfunction

    // Update the table copy for a load, or queue the acceleration for a query.
    task automatic note_request(input req_t r, input bit typed, input accel_t given);
        accel_t e;
        if (r.is_query == ACT_QUERY) begin
            e = typed ? given : accel_at(r.x, r.y, r.z);
            if (e.sat) n_clamped++;
            accel_expected = {accel_expected, e};
            n_queries++;
        end else begin
            body_x[r.slot] = r.x;
            body_y[r.slot] = r.y;
            body_z[r.slot] = r.z;
            body_mu[r.slot] = r.mu;
            body_valid[r.slot] = 1'b1;
            n_loads++;
        end
    endtask

    // Present one request, in bursts with random gaps, until it is accepted.
    int burst_left = 0;
    task automatic send_request(input req_t r, input bit typed, input accel_t given);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 3))
                @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tuser = r.is_query;
        s_axis_tdata = '0;
        s_axis_tdata[3:0] = r.slot;
        s_axis_tdata[51:4] = r.x;
        s_axis_tdata[99:52] = r.y;
        s_axis_tdata[147:100] = r.z;
        s_axis_tdata[211:148] = r.mu;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        note_request(r, typed, given);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic signed [47:0] rand_pos();
        logic [63:0] v;
        logic signed [47:0] p;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 1)) return v[47:0];
        // Small coordinates so that the terms stay in range.
        p = 48'(v[47:0] & ((48'd1 << $urandom_range(8, 40)) - 1));
        return $urandom_range(0, 1) ? -p : p;
    endfunction

    function automatic logic [63:0] rand_mu();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) return v;
        return v >> $urandom_range(8, 60);
    endfunction

    // Receiver: switch between always ready, random and long stalls.
    int rx_mode = 0;
    int rx_count = 0;
    always @(negedge i_clk) begin
        if (rx_count == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_count = $urandom_range(50, 400);
        end
        rx_count--;
        case (rx_mode)
            0: begin
                m_axis_tready = 1'b1;
            end
            1: begin
                m_axis_tready = $urandom_range(0, 1);
            end
            default: begin
                m_axis_tready = ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        accel_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (accel_expected.size() == 0) begin
                $error("result with no query waiting: %h", m_axis_tdata);
                n_errors++;
            end else begin
                e = accel_expected.pop_front();
                if (m_axis_tdata[47:0] !== e.ax) begin
                    $error("accel_x expected %h actual %h", e.ax, m_axis_tdata[47:0]);
                    n_errors++;
                end
                if (m_axis_tdata[95:48] !== e.ay) begin
                    $error("accel_y expected %h actual %h", e.ay, m_axis_tdata[95:48]);
                    n_errors++;
                end
                if (m_axis_tdata[143:96] !== e.az) begin
                    $error("accel_z expected %h actual %h", e.az, m_axis_tdata[143:96]);
                    n_errors++;
                end
                if (m_axis_tdata[144] !== e.sat) begin
                    $error("saturated expected %b actual %b", e.sat, m_axis_tdata[144]);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus: directed table first, then random loads and queries.
    initial begin
        row_t   rows [N_DIRECTED];
        req_t   r;
        accel_t none;
        accel_t zero;
        int     k;
        none = '{0, 0, 0, 0};
        zero = '{0, 0, 0, 0};
        for (int i = 0; i < MAX_BODIES; i++) begin
            body_x[i] = '0; body_y[i] = '0; body_z[i] = '0;
            body_mu[i] = '0; body_valid[i] = 1'b0;
        end

        // Empty table, then one body of mu = 1 at the origin.
        rows[0]  = '{'{ACT_QUERY, 4'd0, 0, 0, 0, 0}, 1, zero};
        rows[1]  = '{'{ACT_QUERY, 4'd9, 48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000,
                      48'sh7FFF_FFFF_FFFF, '1}, 1, zero};
        rows[2]  = '{'{ACT_LOAD, 4'd0, 0, 0, 0, 64'd1 << 14}, 0, none};
        // Coincident body adds nothing.
        rows[3]  = '{'{ACT_QUERY, 4'd0, 0, 0, 0, 0}, 1, zero};
        // One metre away along x: exactly -1 m/s^2.
        rows[4]  = '{'{ACT_QUERY, 4'd0, 48'sd65536, 0, 0, 0}, 1,
                     '{48'shFFFF_0000_0000, 0, 0, 0}};
        rows[5]  = '{'{ACT_LOAD, 4'd15, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF,
                      48'sh7FFF_FFFF_FFFF, '1}, 0, none};
        rows[6]  = '{'{ACT_QUERY, 4'd0, 48'sh8000_0000_0000, 48'sh8000_0000_0000,
                      48'sh8000_0000_0000, 0}, 0, none};
        // Heavy body one raw unit from the origin: the term clamps.
        rows[7]  = '{'{ACT_LOAD, 4'd1, 48'sd1, 0, 0, '1}, 0, none};
        rows[8]  = '{'{ACT_QUERY, 4'd0, 0, 0, 0, 0}, 0, none};
        rows[9]  = '{'{ACT_LOAD, 4'd2, 48'sh8000_0000_0000, 48'sh8000_0000_0000,
                      48'sh8000_0000_0000, 64'd0}, 0, none};
        rows[10] = '{'{ACT_QUERY, 4'd0, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF,
                      48'sh7FFF_FFFF_FFFF, 0}, 0, none};
        rows[11] = '{'{ACT_LOAD, 4'd1, 48'sd65536000, -48'sd65536000, 48'sd1,
                      64'd1 << 40}, 0, none};
        rows[12] = '{'{ACT_QUERY, 4'd0, -48'sd65536, 48'sd65536, 48'sd0, 0}, 0, none};
        rows[13] = '{'{ACT_QUERY, 4'd0, 48'sd65536000, -48'sd65536000, 48'sd1000, 0},
                     0, none};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(rows[i].req, rows[i].typed, rows[i].res);

        for (int i = 0; i < N_RANDOM; i++) begin
            r.is_query = ($urandom_range(0, 9) == 0) ? ACT_QUERY : ACT_LOAD;
            // Keep the table small in the first half so queries stay short.
            r.slot = (i < N_RANDOM / 2) ? 4'($urandom_range(0, 3)) : 4'($urandom);
            r.x = rand_pos();
            r.y = rand_pos();
            r.z = rand_pos();
            r.mu = rand_mu();
            if (r.is_query == ACT_QUERY && $urandom_range(0, 1)) begin
                // Query near a stored body.
                k = $urandom_range(0, MAX_BODIES - 1);
                r.x = body_x[k] + 48'(($urandom_range(0, 1) ? -1 : 1)
                      * longint'($urandom_range(0, 1 << $urandom_range(0, 28))));
                r.y = body_y[k] + 48'(longint'($urandom_range(0, 1 << $urandom_range(0, 28))));
                r.z = $urandom_range(0, 3) == 0 ? body_z[k] : body_z[k] - 48'sd65536;
            end
            send_request(r, 0, none);
        end

        stim_done = 1'b1;
        while (accel_expected.size() != 0) @(posedge i_clk);
        repeat (12000) @(posedge i_clk);

        $display("Sent %0d loads and %0d queries; checked %0d results, %0d saturated.",
                 n_loads, n_queries, n_results, n_clamped);
        if (n_errors == 0 && accel_expected.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Run limit.
    initial begin
        #1_000_000_000;
        $display("Timed out with %0d results outstanding.", accel_expected.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
